@@ src/assert_macros.svh @@
// assertion helpers, clocked on aclk and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/wavp_pkg.sv @@
`default_nettype none
package wavp_pkg;

    localparam int MAX_CHANNELS   = 8;
    localparam int MIN_FILE_BYTES = 44;
    localparam int CNT_W          = $clog2(MIN_FILE_BYTES + 1);
    localparam int SUM_W          = 19;

    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;
    localparam logic [31:0] RIFF_TAG = 32'h5249_4646;
    localparam logic [31:0] WAVE_TAG = 32'h5741_5645;
    localparam logic [4:0]  FMT_FIELD_BYTES = 5'd16;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
    localparam logic [2:0] ST_UNSUPP    = 3'd3;
    localparam logic [2:0] ST_TOO_MANY  = 3'd4;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_RIFF = 3'd0,
        PH_CHDR = 3'd1,
        PH_FMT  = 3'd2,
        PH_SKIP = 3'd3,
        PH_PAD  = 3'd4,
        PH_DATA = 3'd5,
        PH_DONE = 3'd6
    } phase_t;

    typedef struct packed {
        logic                    kind;
        logic signed [SUM_W-1:0] mono_sum;
        logic [15:0]             channel_count;
        logic [31:0]             source_rate;
        logic [2:0]              status;
        logic                    last;
    } result_t;

    typedef struct packed {
        logic    frame_v;
        logic    status_v;
        result_t frame;
        result_t stat;
    } push_t;

    typedef struct packed {
        logic [LVL_W-1:0] level;
    } fifo_stat_t;

endpackage
`default_nettype wire

@@ src/wav_pcm16_stream_parser.sv @@
// a result item is written into the output queue as the byte that completes it is taken
// throughput: one file byte per cycle while s_ready is high; a byte that closes both a frame
// and the file yields two items; the four-entry output queue drains one item a cycle while
// m_ready is high and holds s_ready low when fewer than two slots are free
// reset: synchronous on aresetn low, clears parser state and empties the queue
`default_nettype none
`include "assert_macros.svh"
module wav_pcm16_stream_parser (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // byte input
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_file_byte,
    input  wire logic               s_end_of_file,
    // result output
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_kind,
    output logic signed [18:0]      m_mono_sum,
    output logic [15:0]             m_channel_count,
    output logic [31:0]             m_source_rate,
    output logic [2:0]              m_status,
    output logic                    m_last
);

    logic                  accept;
    wavp_pkg::push_t       push;
    wavp_pkg::result_t     out_item;
    wavp_pkg::fifo_stat_t  fifo_stat;

    // a byte is taken whenever it is valid and the queue can absorb its worst case
    assign accept = s_valid && s_ready;

    // chunk walker, fmt field capture and frame summing
    wavp_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .file_byte   (s_file_byte),
        .end_of_file (s_end_of_file),
        .push        (push)
    );

    // result queue, parts the byte side from the result side
    wavp_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .has_room  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_item  (out_item),
        .stat      (fifo_stat)
    );

    assign m_kind          = out_item.kind;
    assign m_mono_sum      = out_item.mono_sum;
    assign m_channel_count = out_item.channel_count;
    assign m_source_rate   = out_item.source_rate;
    assign m_status        = out_item.status;
    assign m_last          = out_item.last;

    // ready only offered with at least two free slots
    `ASSERT_IMP(a_room_when_ready, s_ready,
        fifo_stat.level <= wavp_pkg::LVL_W'(wavp_pkg::FIFO_DEPTH - 2))
    // the closing byte always leaves its status item queued
    `ASSERT_NXT(a_status_queued, accept && s_end_of_file, m_valid)
    // output valid follows the queue level
    `ASSERT_IMP(a_empty_no_valid, fifo_stat.level == '0, !m_valid)
    // a frame item never carries a status code or the last flag
    `ASSERT_IMP(a_frame_clean, m_valid && !m_kind,
        !m_last && (m_status == wavp_pkg::ST_OK))

endmodule
`default_nettype wire

@@ src/wavp_parser.sv @@
`default_nettype none
module wavp_parser (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           accept,
    input  wire logic [7:0]     file_byte,
    input  wire logic           end_of_file,
    output wavp_pkg::push_t     push
);

    wavp_pkg::phase_t            phase_reg, phase_next;
    logic [wavp_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [31:0]                 tag_reg, tag_next;
    logic [31:0]                 rem_reg, rem_next;
    logic [4:0]                  hp_reg, hp_next;
    logic                        magic_reg, magic_next;
    logic [15:0]                 fmt_reg, fmt_next;
    logic [15:0]                 ch_reg, ch_next;
    logic [31:0]                 rate_reg, rate_next;
    logic [15:0]                 bits_reg, bits_next;
    logic                        data_reg, data_next;
    logic [7:0]                  low_reg, low_next;
    logic [15:0]                 ci_reg, ci_next;
    logic [wavp_pkg::SUM_W-1:0]  acc_reg, acc_next;
    logic                        pad_reg, pad_next;

    logic                        frame_v;
    logic [wavp_pkg::SUM_W-1:0]  frame_sum;
    logic [2:0]                  status_code;
    logic                        allowed;

    assign allowed = magic_reg && (fmt_reg == 16'd1) && (bits_reg == 16'd16)
                     && (ch_reg != 16'd0)
                     && (ch_reg <= 16'(wavp_pkg::MAX_CHANNELS));

    always_comb begin
        logic [31:0] rem_or;
        logic [31:0] rem_dec;
        logic [15:0] raw;
        logic [15:0] ci1;
        logic [wavp_pkg::SUM_W-1:0] acc1;

        phase_next = phase_reg;
        tag_next   = tag_reg;
        rem_next   = rem_reg;
        hp_next    = hp_reg;
        magic_next = magic_reg;
        fmt_next   = fmt_reg;
        ch_next    = ch_reg;
        rate_next  = rate_reg;
        bits_next  = bits_reg;
        data_next  = data_reg;
        low_next   = low_reg;
        ci_next    = ci_reg;
        acc_next   = acc_reg;
        pad_next   = pad_reg;
        frame_v    = 1'b0;
        frame_sum  = '0;

        cnt_next = (cnt_reg == wavp_pkg::CNT_W'(wavp_pkg::MIN_FILE_BYTES))
                   ? cnt_reg : cnt_reg + 1'b1;

        rem_or  = rem_reg | ({24'd0, file_byte} << {hp_reg[1:0], 3'b000});
        rem_dec = rem_reg - 32'd1;
        raw     = {file_byte, low_reg};
        acc1    = acc_reg + {{(wavp_pkg::SUM_W-16){raw[15]}}, raw};
        ci1     = ci_reg + 16'd1;

        unique case (phase_reg) inside
            wavp_pkg::PH_RIFF: begin
                if (hp_reg < 5'd4) begin
                    if (file_byte != wavp_pkg::RIFF_TAG[8*(3-hp_reg[1:0]) +: 8])
                        magic_next = 1'b0;
                end else if (hp_reg >= 5'd8) begin
                    if (file_byte != wavp_pkg::WAVE_TAG[8*(3-hp_reg[1:0]) +: 8])
                        magic_next = 1'b0;
                end
                if (hp_reg >= 5'd11) begin
                    phase_next = wavp_pkg::PH_CHDR;
                    hp_next    = 5'd0;
                end else begin
                    hp_next = hp_reg + 5'd1;
                end
            end
            wavp_pkg::PH_CHDR: begin
                if (hp_reg < 5'd4) begin
                    tag_next = {tag_reg[23:0], file_byte};
                    if (hp_reg == 5'd0) rem_next = '0;
                    hp_next = hp_reg + 5'd1;
                end else begin
                    rem_next = rem_or;
                    if (hp_reg < 5'd7) begin
                        hp_next = hp_reg + 5'd1;
                    end else begin
                        hp_next  = 5'd0;
                        pad_next = rem_or[0];
                        if (tag_reg == wavp_pkg::TAG_DATA) begin
                            data_next  = 1'b1;
                            ci_next    = '0;
                            acc_next   = '0;
                            low_next   = '0;
                            phase_next = (rem_or == '0) ? wavp_pkg::PH_DONE
                                                        : wavp_pkg::PH_DATA;
                        end else if (tag_reg == wavp_pkg::TAG_FMT) begin
                            fmt_next   = '0;
                            ch_next    = '0;
                            rate_next  = '0;
                            bits_next  = '0;
                            phase_next = (rem_or == '0) ? wavp_pkg::PH_CHDR
                                                        : wavp_pkg::PH_FMT;
                        end else begin
                            phase_next = (rem_or == '0) ? wavp_pkg::PH_CHDR
                                                        : wavp_pkg::PH_SKIP;
                        end
                    end
                end
            end
            wavp_pkg::PH_FMT, wavp_pkg::PH_SKIP: begin
                if (phase_reg == wavp_pkg::PH_FMT && hp_reg < wavp_pkg::FMT_FIELD_BYTES) begin
                    case (hp_reg[3:0])
                        4'd0:  fmt_next[7:0]    = file_byte;
                        4'd1:  fmt_next[15:8]   = file_byte;
                        4'd2:  ch_next[7:0]     = file_byte;
                        4'd3:  ch_next[15:8]    = file_byte;
                        4'd4:  rate_next[7:0]   = file_byte;
                        4'd5:  rate_next[15:8]  = file_byte;
                        4'd6:  rate_next[23:16] = file_byte;
                        4'd7:  rate_next[31:24] = file_byte;
                        4'd14: bits_next[7:0]   = file_byte;
                        4'd15: bits_next[15:8]  = file_byte;
                        default: ;
                    endcase
                    hp_next = hp_reg + 5'd1;
                end
                rem_next = rem_dec;
                if (rem_dec == '0) begin
                    if (pad_reg) begin
                        phase_next = wavp_pkg::PH_PAD;
                    end else begin
                        phase_next = wavp_pkg::PH_CHDR;
                        hp_next    = 5'd0;
                    end
                end
            end
            wavp_pkg::PH_PAD: begin
                pad_next   = 1'b0;
                phase_next = wavp_pkg::PH_CHDR;
                hp_next    = 5'd0;
            end
            wavp_pkg::PH_DATA: begin
                if (!hp_reg[0]) begin
                    low_next = file_byte;
                end else if (ci1 >= ch_reg) begin
                    frame_v   = allowed;
                    frame_sum = acc1;
                    ci_next   = '0;
                    acc_next  = '0;
                end else begin
                    ci_next  = ci1;
                    acc_next = acc1;
                end
                hp_next  = {4'd0, ~hp_reg[0]};
                rem_next = rem_dec;
                if (rem_dec == '0) phase_next = wavp_pkg::PH_DONE;
            end
            default: ;
        endcase
    end

    // status from the updated state, as the byte that ends the file sees it
    always_comb begin
        if (cnt_next < wavp_pkg::CNT_W'(wavp_pkg::MIN_FILE_BYTES))
            status_code = wavp_pkg::ST_SHORT;
        else if (!magic_next)
            status_code = wavp_pkg::ST_BAD_MAGIC;
        else if (fmt_next != 16'd1 || bits_next != 16'd16 || !data_next || ch_next == 16'd0)
            status_code = wavp_pkg::ST_UNSUPP;
        else if (ch_next > 16'(wavp_pkg::MAX_CHANNELS))
            status_code = wavp_pkg::ST_TOO_MANY;
        else
            status_code = wavp_pkg::ST_OK;
    end

    always_comb begin
        push.frame_v              = accept && frame_v;
        push.status_v             = accept && end_of_file;
        push.frame.kind           = 1'b0;
        push.frame.mono_sum       = frame_sum;
        push.frame.channel_count  = ch_next;
        push.frame.source_rate    = rate_next;
        push.frame.status         = wavp_pkg::ST_OK;
        push.frame.last           = 1'b0;
        push.stat.kind            = 1'b1;
        push.stat.mono_sum        = '0;
        push.stat.channel_count   = ch_next;
        push.stat.source_rate     = rate_next;
        push.stat.status          = status_code;
        push.stat.last            = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && end_of_file)) begin
            phase_reg <= wavp_pkg::PH_RIFF;
            cnt_reg   <= '0;
            tag_reg   <= '0;
            rem_reg   <= '0;
            hp_reg    <= '0;
            magic_reg <= 1'b1;
            fmt_reg   <= '0;
            ch_reg    <= '0;
            rate_reg  <= '0;
            bits_reg  <= '0;
            data_reg  <= 1'b0;
            low_reg   <= '0;
            ci_reg    <= '0;
            acc_reg   <= '0;
            pad_reg   <= 1'b0;
        end else if (accept) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            tag_reg   <= tag_next;
            rem_reg   <= rem_next;
            hp_reg    <= hp_next;
            magic_reg <= magic_next;
            fmt_reg   <= fmt_next;
            ch_reg    <= ch_next;
            rate_reg  <= rate_next;
            bits_reg  <= bits_next;
            data_reg  <= data_next;
            low_reg   <= low_next;
            ci_reg    <= ci_next;
            acc_reg   <= acc_next;
            pad_reg   <= pad_next;
        end
    end

endmodule
`default_nettype wire

@@ src/wavp_out_fifo.sv @@
`default_nettype none
module wavp_out_fifo (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire wavp_pkg::push_t      push,
    output logic                      has_room,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output wavp_pkg::result_t         out_item,
    output wavp_pkg::fifo_stat_t      stat
);

    wavp_pkg::result_t                mem [wavp_pkg::FIFO_DEPTH];
    logic [wavp_pkg::PTR_W-1:0]       wr_reg, wr_next, rd_reg, rd_next;
    logic [wavp_pkg::LVL_W-1:0]       level_reg, level_next;
    logic [wavp_pkg::PTR_W-1:0]       status_addr;
    logic                             pop;

    assign out_valid  = (level_reg != '0);
    assign out_item   = mem[rd_reg];
    assign pop        = out_valid && out_ready;
    // room for two items so a byte never has to wait on the output side mid-way
    assign has_room   = (level_reg <= wavp_pkg::LVL_W'(wavp_pkg::FIFO_DEPTH - 2));
    assign stat.level = level_reg;

    assign status_addr = wr_reg + wavp_pkg::PTR_W'(push.frame_v);
    assign wr_next     = wr_reg + wavp_pkg::PTR_W'(push.frame_v)
                                + wavp_pkg::PTR_W'(push.status_v);
    assign rd_next     = rd_reg + wavp_pkg::PTR_W'(pop);
    assign level_next  = level_reg + wavp_pkg::LVL_W'(push.frame_v)
                                   + wavp_pkg::LVL_W'(push.status_v)
                                   - wavp_pkg::LVL_W'(pop);

    always_ff @(posedge aclk) begin
        if (push.frame_v) mem[wr_reg] <= push.frame;
        if (push.status_v) mem[status_addr] <= push.stat;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            level_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            level_reg <= level_next;
        end
    end

endmodule
`default_nettype wire
